[hdl/obb_overlap_test_defines.svh]
// ----------------------------------------------------------------------------
// obb_overlap_test_defines.svh
// Assertion macros for the box overlap test block.
// ----------------------------------------------------------------------------
`ifndef OBB_OVERLAP_TEST_DEFINES_SVH
`define OBB_OVERLAP_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define OBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("obb assertion failed");
`define OBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("obb assertion failed");
`else
`define OBB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OBB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/obb_pkg.sv]
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types and constants of the box overlap test block.
// ----------------------------------------------------------------------------
`default_nettype none
package obb_pkg;

    localparam int DEF_COMPONENT_WIDTH = 24;
    localparam int FRAC_BITS           = 12;
    localparam int DIGIT_BITS          = 8;
    localparam int NUM_VECS            = 11;

    localparam logic [3:0] CMD_LAST_LOAD = 4'd10;
    localparam logic [3:0] CMD_TEST      = 4'd11;

    localparam logic [3:0] VEC_AX0 = 4'd0;
    localparam logic [3:0] VEC_AC  = 4'd3;
    localparam logic [3:0] VEC_AE  = 4'd4;
    localparam logic [3:0] VEC_BX0 = 4'd5;
    localparam logic [3:0] VEC_BC  = 4'd8;
    localparam logic [3:0] VEC_BE  = 4'd9;
    localparam logic [3:0] VEC_OFF = 4'd10;

    localparam logic [3:0] LAST_IDX = 4'd14;

    typedef enum logic [2:0] {
        SRC_VEC,
        SRC_TV,
        SRC_RM,
        SRC_T,
        SRC_ONE,
        SRC_ONE24
    } t_src_kind;

    typedef struct packed {
        t_src_kind  kind;
        logic [3:0] vec;
        logic [3:0] idx;
    } t_src;

    typedef struct packed {
        logic       clr;
        logic       mac_start;
        logic       dst_r;
        logic       sub;
        logic       abs_x;
        t_src       src_x;
        t_src       src_y;
        logic       store_en;
        logic [3:0] store_idx;
        logic       cmp_cross;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic mac_done;
        logic separated;
    } t_dp_stat;

endpackage
`default_nettype wire

[hdl/obb_overlap_test.sv]
// ----------------------------------------------------------------------------
// obb_overlap_test
// Separating axis overlap test of two oriented boxes over fifteen axes.
//
// Channel  Direction  Handshake          Beat
// in       sink       i_valid / o_stall  command, component_x/y/z
// out      source     o_valid / i_stall  boxes_overlap
//
// A load beat (commands 0-10) writes one vector. A test beat runs 15 dot
// products, then up to 15 axes, on one shared digit-serial multiplier
// whose serial operand has NDIG = ceil((2*COMPONENT_WIDTH+4)/8) 8-bit digits.
// The input stalls while a test runs, and a test waits for the previous
// result to be taken. Reset clears control only; the vector store is
// undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "obb_overlap_test_defines.svh"
module obb_overlap_test
    import obb_pkg::*;
#(
    parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [3:0]                        i_command,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_component_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_component_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_component_z,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_boxes_overlap
);

    localparam int RAW = $clog2(NUM_VECS);

    t_dp_cmd                    dp_cmd;
    t_dp_stat                   dp_stat;
    logic                       ram_we;
    logic [RAW-1:0]             ram_raddr;
    logic [3*COMPONENT_WIDTH-1:0] ram_rdata;

    assign ram_we = i_valid && !o_stall && (i_command <= CMD_LAST_LOAD);

    obb_ram #(
        .WIDTH (3 * COMPONENT_WIDTH),
        .DEPTH (NUM_VECS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_command[RAW-1:0]),
        .i_wdata ({i_component_z, i_component_y, i_component_x}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    obb_dp #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata)
    );

    obb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_boxes_overlap (o_boxes_overlap),
        .o_cmd           (dp_cmd),
        .i_stat          (dp_stat)
    );

    `OBB_ASSERT_NXT(a_test_holds_stall, i_clk, i_rst_n, i_valid && !o_stall && (i_command == CMD_TEST), o_stall)
    `OBB_ASSERT_IMP(a_mac_when_free, i_clk, i_rst_n, dp_cmd.mac_start, !dp_stat.busy)
    `OBB_ASSERT_IMP(a_mac_alone, i_clk, i_rst_n, dp_cmd.mac_start, !(dp_cmd.clr || dp_cmd.store_en))

endmodule
`default_nettype wire

[hdl/obb_ram.sv]
// ----------------------------------------------------------------------------
// obb_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 11
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hdl/obb_dp.sv]
// ----------------------------------------------------------------------------
// obb_dp
// Datapath: operand fetch, digit-serial multiplier, two accumulators,
// result registers and the separation compare.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_dp
    import obb_pkg::*;
#(
    parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_stat                          o_stat,
    output logic [$clog2(NUM_VECS)-1:0]       o_raddr,
    input  wire logic [3*COMPONENT_WIDTH-1:0] i_rdata
);

    localparam int W    = COMPONENT_WIDTH;
    localparam int MW   = 2 * W + 4;
    localparam int AW   = 2 * MW;
    localparam int NDIG = (MW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int NB   = NDIG * DIGIT_BITS;
    localparam int PW   = 2 * NB;
    localparam int CW   = AW + FRAC_BITS + 1;
    localparam int CNTW = $clog2(NDIG + 1);
    localparam int RAW  = $clog2(NUM_VECS);

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_FX,
        DP_FY,
        DP_MUL,
        DP_ACC
    } t_dp_state;

    t_dp_state               r_state;
    t_dp_cmd                 r_cmd;
    logic [MW-1:0]           r_mx;
    logic                    r_sx;
    logic [NB-1:0]           r_my;
    logic                    r_neg;
    logic [PW-1:0]           r_prod;
    logic [CNTW-1:0]         r_cnt;
    logic                    r_done;
    logic signed [AW-1:0]    r_acc_d;
    logic signed [AW-1:0]    r_acc_r;
    logic signed [W+1:0]     r_tv [3];
    logic signed [MW-1:0]    r_rm [9];
    logic signed [MW-1:0]    r_t  [3];

    t_src                    op_src;
    logic [W-1:0]            comp;
    logic signed [MW-1:0]    op_val;
    logic                    op_neg;
    logic [MW-1:0]           op_mag;
    logic [MW+DIGIT_BITS-1:0] pp;
    logic [AW-1:0]           prod_lo;
    logic signed [AW-1:0]    addend;
    logic [AW-1:0]           d_abs;
    logic signed [CW-1:0]    lhs;
    logic signed [CW-1:0]    rhs;
    logic [3:0]              rm_sel;

    always_comb begin
        op_src = (r_state == DP_FX) ? r_cmd.src_x : r_cmd.src_y;
        case (op_src.idx[1:0])
            2'd0:    comp = i_rdata[W-1:0];
            2'd1:    comp = i_rdata[2*W-1:W];
            default: comp = i_rdata[3*W-1:2*W];
        endcase
        case (op_src.kind)
            SRC_VEC:   op_val = {{(MW-W){comp[W-1]}}, comp};
            SRC_TV:    op_val = {{(MW-W-2){r_tv[op_src.idx[1:0]][W+1]}},
                                 r_tv[op_src.idx[1:0]]};
            SRC_RM:    op_val = r_rm[op_src.idx];
            SRC_T:     op_val = r_t[op_src.idx[1:0]];
            SRC_ONE:   op_val = MW'(1);
            default:   op_val = MW'(1) << (2 * FRAC_BITS);
        endcase
        op_neg = op_val[MW-1] && !((r_state == DP_FX) && r_cmd.abs_x);
        op_mag = op_val[MW-1] ? MW'(-op_val) : MW'(op_val);
    end

    always_comb begin
        if (r_state == DP_IDLE) begin
            o_raddr = i_cmd.src_x.vec[RAW-1:0];
        end else begin
            o_raddr = r_cmd.src_y.vec[RAW-1:0];
        end
    end

    assign pp      = r_mx * r_my[NB-1 -: DIGIT_BITS];
    assign prod_lo = r_prod[AW-1:0];
    assign addend  = r_neg ? -$signed(prod_lo) : $signed(prod_lo);
    assign rm_sel  = i_cmd.store_idx - 4'd3;

    always_comb begin
        d_abs = r_acc_d[AW-1] ? AW'(-r_acc_d) : AW'(r_acc_d);
        if (i_cmd.cmp_cross) begin
            lhs = {{(FRAC_BITS+1){1'b0}}, d_abs};
            rhs = {r_acc_r[AW-1], r_acc_r, {FRAC_BITS{1'b0}}};
        end else begin
            lhs = {1'b0, d_abs, {FRAC_BITS{1'b0}}};
            rhs = {{(FRAC_BITS+1){r_acc_r[AW-1]}}, r_acc_r};
        end
    end

    assign o_stat.busy      = (r_state != DP_IDLE);
    assign o_stat.mac_done  = r_done;
    assign o_stat.separated = (lhs > rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                DP_IDLE: begin
                    if (i_cmd.mac_start) begin
                        r_state <= DP_FX;
                    end
                end
                DP_FX:  r_state <= DP_FY;
                DP_FY:  r_state <= DP_MUL;
                DP_MUL: begin
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= DP_ACC;
                    end
                end
                DP_ACC: begin
                    r_state <= DP_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= DP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_start) begin
            r_cmd <= i_cmd;
        end
        if (r_state == DP_FX) begin
            r_mx <= op_mag;
            r_sx <= op_neg;
        end
        if (r_state == DP_FY) begin
            r_my   <= NB'(op_mag);
            r_neg  <= r_sx ^ op_neg ^ r_cmd.sub;
            r_prod <= '0;
            r_cnt  <= CNTW'(NDIG);
        end
        if (r_state == DP_MUL) begin
            r_prod <= (r_prod << DIGIT_BITS) + PW'(pp);
            r_my   <= r_my << DIGIT_BITS;
            r_cnt  <= r_cnt - CNTW'(1);
        end
        if (i_cmd.clr) begin
            r_acc_d <= '0;
            r_acc_r <= '0;
        end else if (r_state == DP_ACC) begin
            if (r_cmd.dst_r) begin
                r_acc_r <= r_acc_r + addend;
            end else begin
                r_acc_d <= r_acc_d + addend;
            end
        end
        if (i_cmd.store_en) begin
            if (i_cmd.store_idx < 4'd3) begin
                r_tv[i_cmd.store_idx[1:0]] <= r_acc_d[W+1:0];
            end else if (i_cmd.store_idx < 4'd12) begin
                r_rm[rm_sel] <= r_acc_d[MW-1:0];
            end else begin
                r_t[2'(i_cmd.store_idx - 4'd12)] <= r_acc_d[MW-1:0];
            end
        end
    end

endmodule
`default_nettype wire

[hdl/obb_ctrl.sv]
// ----------------------------------------------------------------------------
// obb_ctrl
// Controller: input handshake, test sequencing over dot products and the
// fifteen axes, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_ctrl
    import obb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [3:0] i_command,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_boxes_overlap,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_stat   i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_MAC,
        S_WAIT,
        S_STORE,
        S_CMP
    } t_state;

    typedef struct packed {
        t_src x;
        t_src y;
        logic abs_x;
        logic sub;
        logic dst_r;
        logic last;
    } t_uop;

    t_state     r_state, n_state;
    logic       r_axis, n_axis;
    logic [3:0] r_idx, n_idx;
    logic [2:0] r_term, n_term;
    logic       r_out_valid, n_out_valid;
    logic       r_overlap, n_overlap;
    t_uop       uop;
    logic       accept;

    function automatic logic [1:0] div3(input logic [3:0] v);
        if (v >= 4'd6) begin
            return 2'd2;
        end else if (v >= 4'd3) begin
            return 2'd1;
        end
        return 2'd0;
    endfunction

    function automatic logic [1:0] rem3(input logic [3:0] v);
        logic [1:0] q;
        logic [3:0] q3;
        q  = div3(v);
        q3 = {2'b00, q} + {1'b0, q, 1'b0};
        return 2'(v - q3);
    endfunction

    function automatic logic [1:0] nxt3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    function automatic t_src vsrc(input logic [3:0] base, input logic [1:0] c);
        return '{kind: SRC_VEC, vec: base, idx: {2'b00, c}};
    endfunction

    function automatic t_src rsrc(input t_src_kind k, input logic [3:0] n);
        return '{kind: k, vec: 4'd0, idx: n};
    endfunction

    function automatic t_src rm(input logic [1:0] i, input logic [1:0] j);
        return rsrc(SRC_RM, {2'b00, i} * 4'd3 + {2'b00, j});
    endfunction

    function automatic t_uop gen_uop(input logic axis_ph, input logic [3:0] idx,
                                     input logic [2:0] term);
        t_uop       u;
        logic [3:0] d;
        logic [1:0] i, j, k, i1, i2, j1, j2;
        u.x     = rsrc(SRC_ONE, 4'd0);
        u.y     = rsrc(SRC_ONE, 4'd0);
        u.abs_x = 1'b0;
        u.sub   = 1'b0;
        u.dst_r = 1'b0;
        u.last  = 1'b0;
        k       = term[1:0];
        if (!axis_ph) begin
            u.last = (term == 3'd2);
            if (idx < 4'd3) begin
                case (term)
                    3'd0: u.x = vsrc(VEC_BC, idx[1:0]);
                    3'd1: begin
                        u.x   = vsrc(VEC_AC, idx[1:0]);
                        u.sub = 1'b1;
                    end
                    default: u.x = vsrc(VEC_OFF, idx[1:0]);
                endcase
            end else if (idx < 4'd12) begin
                d   = idx - 4'd3;
                i   = div3(d);
                j   = rem3(d);
                u.x = vsrc(VEC_AX0 + {2'b00, i}, k);
                u.y = vsrc(VEC_BX0 + {2'b00, j}, k);
            end else begin
                d   = idx - 4'd12;
                u.x = vsrc(VEC_AX0 + {2'b00, d[1:0]}, k);
                u.y = rsrc(SRC_TV, {2'b00, k});
            end
        end else if (idx < 4'd3) begin
            i      = idx[1:0];
            u.last = (term == 3'd4);
            case (term)
                3'd0: u.x = rsrc(SRC_T, {2'b00, i});
                3'd1: begin
                    u.x     = vsrc(VEC_AE, i);
                    u.y     = rsrc(SRC_ONE24, 4'd0);
                    u.dst_r = 1'b1;
                end
                default: begin
                    j       = 2'(term - 3'd2);
                    u.x     = rm(i, j);
                    u.abs_x = 1'b1;
                    u.y     = vsrc(VEC_BE, j);
                    u.dst_r = 1'b1;
                end
            endcase
        end else if (idx < 4'd6) begin
            d      = idx - 4'd3;
            j      = d[1:0];
            u.last = (term == 3'd6);
            case (term) inside
                3'd0, 3'd1, 3'd2: begin
                    u.x = rsrc(SRC_TV, {2'b00, k});
                    u.y = vsrc(VEC_BX0 + {2'b00, j}, k);
                end
                3'd3: begin
                    u.x     = vsrc(VEC_BE, j);
                    u.y     = rsrc(SRC_ONE24, 4'd0);
                    u.dst_r = 1'b1;
                end
                default: begin
                    i       = 2'(term - 3'd4);
                    u.x     = rm(i, j);
                    u.abs_x = 1'b1;
                    u.y     = vsrc(VEC_AE, i);
                    u.dst_r = 1'b1;
                end
            endcase
        end else begin
            d      = idx - 4'd6;
            i      = div3(d);
            j      = rem3(d);
            i1     = nxt3(i);
            i2     = nxt3(i1);
            j1     = nxt3(j);
            j2     = nxt3(j1);
            u.last = (term == 3'd5);
            u.abs_x = (term >= 3'd2);
            u.dst_r = (term >= 3'd2);
            case (term)
                3'd0: begin
                    u.x = rsrc(SRC_T, {2'b00, i2});
                    u.y = rm(i1, j);
                end
                3'd1: begin
                    u.x   = rsrc(SRC_T, {2'b00, i1});
                    u.y   = rm(i2, j);
                    u.sub = 1'b1;
                end
                3'd2: begin
                    u.x = rm(i2, j);
                    u.y = vsrc(VEC_AE, i1);
                end
                3'd3: begin
                    u.x = rm(i1, j);
                    u.y = vsrc(VEC_AE, i2);
                end
                3'd4: begin
                    u.x = rm(i, j2);
                    u.y = vsrc(VEC_BE, j1);
                end
                default: begin
                    u.x = rm(i, j1);
                    u.y = vsrc(VEC_BE, j2);
                end
            endcase
        end
        return u;
    endfunction

    assign uop     = gen_uop(r_axis, r_idx, r_term);
    assign o_stall = (r_state != S_IDLE) || (r_out_valid && (i_command == CMD_TEST));
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_boxes_overlap = r_overlap;

    always_comb begin
        o_cmd.clr       = (r_state == S_CLR);
        o_cmd.mac_start = (r_state == S_MAC);
        o_cmd.dst_r     = uop.dst_r;
        o_cmd.sub       = uop.sub;
        o_cmd.abs_x     = uop.abs_x;
        o_cmd.src_x     = uop.x;
        o_cmd.src_y     = uop.y;
        o_cmd.store_en  = (r_state == S_STORE);
        o_cmd.store_idx = r_idx;
        o_cmd.cmp_cross = r_axis && (r_idx >= 4'd6);
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_idx       = r_idx;
        n_term      = r_term;
        n_out_valid = r_out_valid && i_stall;
        n_overlap   = r_overlap;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_TEST)) begin
                    n_state = S_CLR;
                    n_axis  = 1'b0;
                    n_idx   = 4'd0;
                end
            end
            S_CLR: begin
                n_term  = 3'd0;
                n_state = S_MAC;
            end
            S_MAC: n_state = S_WAIT;
            S_WAIT: begin
                if (i_stat.mac_done) begin
                    if (uop.last) begin
                        n_state = r_axis ? S_CMP : S_STORE;
                    end else begin
                        n_term  = r_term + 3'd1;
                        n_state = S_MAC;
                    end
                end
            end
            S_STORE: begin
                n_state = S_CLR;
                if (r_idx == LAST_IDX) begin
                    n_axis = 1'b1;
                    n_idx  = 4'd0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_CMP: begin
                if (i_stat.separated || (r_idx == LAST_IDX)) begin
                    n_out_valid = 1'b1;
                    n_overlap   = !i_stat.separated;
                    n_state     = S_IDLE;
                end else begin
                    n_idx   = r_idx + 4'd1;
                    n_state = S_CLR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_idx       <= 4'd0;
            r_term      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_idx       <= n_idx;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
        r_overlap <= n_overlap;
    end

endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oriented box overlap test block.
//
// Box A, box B and the offset are loaded vector by vector, then test beats
// are issued. A bit-exact predictor on 128-bit signed arithmetic computes
// the overlap flag of each accepted test beat whose row is not typed. A
// short directed table covers touching and separated faces, extremes,
// negative extents and the unused commands. Random box-pair jobs follow,
// in phases with different sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top
    import obb_pkg::*;
();

    localparam int CW       = DEF_COMPONENT_WIDTH;
    localparam int N_SLOTS  = NUM_VECS * 3;
    localparam int N_RANDOM = 1300;
    localparam int CYC_MAX  = 20000000;
    localparam int ONE      = 1 << FRAC_BITS;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd12;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [CW-1:0] t_comp;

    typedef struct {
        logic [3:0] cmd;
        t_comp      x;
        t_comp      y;
        t_comp      z;
        bit         typed;
        bit         overlap;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [3:0] i_command;
    t_comp      i_component_x;
    t_comp      i_component_y;
    t_comp      i_component_z;
    logic       o_valid;
    logic       i_stall;
    logic       o_boxes_overlap;

    t_wide      vec_mem [N_SLOTS];
    bit         overlap_q [$];
    int         err_cnt;
    int         cyc_cnt;
    int         idle_pct;
    int         stall_pct;

    obb_overlap_test #(.COMPONENT_WIDTH(CW)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_component_x  (i_component_x),
        .i_component_y  (i_component_y),
        .i_component_z  (i_component_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_boxes_overlap(o_boxes_overlap)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_wide mag(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // dot product of two stored vectors, given their first slots
    function automatic t_wide dot_slots(int p, int q);
        return vec_mem[p] * vec_mem[q] + vec_mem[p+1] * vec_mem[q+1]
             + vec_mem[p+2] * vec_mem[q+2];
    endfunction

    function automatic bit boxes_overlap_calc();
        t_wide tv [3];
        t_wide tp [3];
        t_wide rm [3][3];
        t_wide ra [3][3];
        t_wide ea [3];
        t_wide eb [3];
        t_wide rad;
        t_wide sep;
        int    i1, i2, j1, j2;
        for (int i = 0; i < 3; i++) begin
            tv[i] = vec_mem[3*VEC_BC+i] - vec_mem[3*VEC_AC+i] + vec_mem[3*VEC_OFF+i];
            ea[i] = vec_mem[3*VEC_AE+i];
            eb[i] = vec_mem[3*VEC_BE+i];
        end
        for (int i = 0; i < 3; i++) begin
            tp[i] = vec_mem[3*i] * tv[0] + vec_mem[3*i+1] * tv[1] + vec_mem[3*i+2] * tv[2];
            for (int j = 0; j < 3; j++) begin
                rm[i][j] = dot_slots(3*i, 3*VEC_BX0 + 3*j);
                ra[i][j] = mag(rm[i][j]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            rad = ea[i] <<< (2*FRAC_BITS);
            for (int j = 0; j < 3; j++) rad += ra[i][j] * eb[j];
            if ((mag(tp[i]) <<< FRAC_BITS) > rad) return 1'b0;
        end
        for (int j = 0; j < 3; j++) begin
            rad = eb[j] <<< (2*FRAC_BITS);
            for (int i = 0; i < 3; i++) rad += ra[i][j] * ea[i];
            sep = tv[0] * vec_mem[3*VEC_BX0+3*j] + tv[1] * vec_mem[3*VEC_BX0+3*j+1]
                + tv[2] * vec_mem[3*VEC_BX0+3*j+2];
            if ((mag(sep) <<< FRAC_BITS) > rad) return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                rad = ea[i1] * ra[i2][j] + ea[i2] * ra[i1][j]
                    + eb[j1] * ra[i][j2] + eb[j2] * ra[i][j1];
                sep = mag(tp[i2] * rm[i1][j] - tp[i1] * rm[i2][j]);
                if (sep > (rad <<< FRAC_BITS)) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // drives one beat, waits for acceptance, then updates the prediction
    task automatic send_beat(input t_row r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= r.cmd;
        i_component_x <= r.x;
        i_component_y <= r.y;
        i_component_z <= r.z;
        do @(posedge i_clk); while (o_stall);
        if (r.cmd <= CMD_LAST_LOAD) begin
            vec_mem[3*r.cmd]   = t_wide'(r.x);
            vec_mem[3*r.cmd+1] = t_wide'(r.y);
            vec_mem[3*r.cmd+2] = t_wide'(r.z);
        end else if (r.cmd == CMD_TEST) begin
            overlap_q.push_back(r.typed ? r.overlap : boxes_overlap_calc());
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_comp rnd_comp(int lo, int hi);
        return t_comp'($urandom_range(hi - lo) + lo);
    endfunction

    function automatic t_row rnd_load(logic [3:0] cmd);
        t_row r;
        int   k;
        r.cmd   = cmd;
        r.typed = 1'b0;
        r.overlap = 1'b0;
        if ($urandom_range(9) == 0) begin
            r.x = t_comp'($urandom);
            r.y = t_comp'($urandom);
            r.z = t_comp'($urandom);
        end else if (cmd == VEC_AC || cmd == VEC_BC) begin
            r.x = rnd_comp(-5 * ONE, 5 * ONE);
            r.y = rnd_comp(-5 * ONE, 5 * ONE);
            r.z = rnd_comp(-5 * ONE, 5 * ONE);
        end else if (cmd == VEC_AE || cmd == VEC_BE) begin
            r.x = rnd_comp(($urandom_range(7) == 0) ? -ONE : 0, 3 * ONE);
            r.y = rnd_comp(0, 3 * ONE);
            r.z = rnd_comp(0, 3 * ONE);
        end else if (cmd == VEC_OFF) begin
            r.x = rnd_comp(-ONE / 2, ONE / 2);
            r.y = rnd_comp(-ONE / 2, ONE / 2);
            r.z = rnd_comp(-ONE / 2, ONE / 2);
        end else if ($urandom_range(1) == 0) begin
            k   = $urandom_range(2);
            r.x = (k == 0) ? t_comp'(($urandom_range(1) ? 1 : -1) * ONE) : t_comp'(0);
            r.y = (k == 1) ? t_comp'(($urandom_range(1) ? 1 : -1) * ONE) : t_comp'(0);
            r.z = (k == 2) ? t_comp'(($urandom_range(1) ? 1 : -1) * ONE) : t_comp'(0);
        end else begin
            r.x = rnd_comp(-ONE, ONE);
            r.y = rnd_comp(-ONE, ONE);
            r.z = rnd_comp(-ONE, ONE);
        end
        return r;
    endfunction

    t_row dir_tbl [] = '{
        '{VEC_AX0,        ONE, 0, 0, 1'b0, 1'b0},
        '{VEC_AX0 + 4'd1, 0, ONE, 0, 1'b0, 1'b0},
        '{VEC_AX0 + 4'd2, 0, 0, ONE, 1'b0, 1'b0},
        '{VEC_AC,         0, 0, 0, 1'b0, 1'b0},
        '{VEC_AE,         ONE, ONE, ONE, 1'b0, 1'b0},
        '{VEC_BX0,        ONE, 0, 0, 1'b0, 1'b0},
        '{VEC_BX0 + 4'd1, 0, ONE, 0, 1'b0, 1'b0},
        '{VEC_BX0 + 4'd2, 0, 0, ONE, 1'b0, 1'b0},
        '{VEC_BC,         0, 0, 0, 1'b0, 1'b0},
        '{VEC_BE,         ONE, ONE, ONE, 1'b0, 1'b0},
        '{VEC_OFF,        0, 0, 0, 1'b0, 1'b0},
        '{CMD_TEST,       0, 0, 0, 1'b1, 1'b1},
        '{VEC_BC,         2 * ONE, 0, 0, 1'b0, 1'b0},
        '{CMD_TEST,       0, 0, 0, 1'b1, 1'b1},
        '{VEC_BC,         2 * ONE + 1, 0, 0, 1'b0, 1'b0},
        '{CMD_TEST,       0, 0, 0, 1'b1, 1'b0},
        '{VEC_OFF,        -1, 0, 0, 1'b0, 1'b0},
        '{CMD_TEST,       0, 0, 0, 1'b1, 1'b1},
        '{VEC_BX0,        2896, 2896, 0, 1'b0, 1'b0},
        '{VEC_BX0 + 4'd1, -2896, 2896, 0, 1'b0, 1'b0},
        '{CMD_TEST,       0, 0, 0, 1'b0, 1'b0},
        '{VEC_AE,         8388607, 8388607, -8388608, 1'b0, 1'b0},
        '{VEC_BC,         -8388608, 8388607, -8388608, 1'b0, 1'b0},
        '{CMD_TEST,       0, 0, 0, 1'b0, 1'b0},
        '{VEC_BE,         -ONE, -ONE, -ONE, 1'b0, 1'b0},
        '{CMD_UNUSED_LO,  -1, -1, -1, 1'b0, 1'b0},
        '{CMD_UNUSED_HI,  5, 6, 7, 1'b0, 1'b0},
        '{CMD_TEST,       0, 0, 0, 1'b0, 1'b0}
    };

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (overlap_q.size() == 0) begin
                $error("unexpected result beat: boxes_overlap %0d", o_boxes_overlap);
                err_cnt++;
            end else if (o_boxes_overlap !== overlap_q[0]) begin
                $error("boxes_overlap: expected %0d, actual %0d",
                       overlap_q[0], o_boxes_overlap);
                err_cnt++;
                void'(overlap_q.pop_front());
            end else begin
                void'(overlap_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYC_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row r;
        int   n_sent;
        int   n_loads;
        err_cnt   = 0;
        cyc_cnt   = 0;
        idle_pct  = 0;
        stall_pct = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_stall       <= 1'b0;
        i_command     <= '0;
        i_component_x <= '0;
        i_component_y <= '0;
        i_component_z <= '0;
        foreach (vec_mem[k]) vec_mem[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[k]) send_beat(dir_tbl[k]);
        drain();

        n_sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 19) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 53 : 19) : 0;
            while (n_sent < (ph + 1) * N_RANDOM / 4) begin
                n_loads = $urandom_range(1, NUM_VECS);
                for (int k = 0; k < n_loads; k++) begin
                    if ($urandom_range(19) == 0) begin
                        r = rnd_load(VEC_AX0);
                        r.cmd = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
                    end else begin
                        r = rnd_load(4'($urandom_range(CMD_LAST_LOAD)));
                    end
                    send_beat(r);
                    n_sent++;
                end
                r = rnd_load(VEC_AX0);
                r.cmd = CMD_TEST;
                send_beat(r);
                n_sent++;
            end
            drain();
        end
        stall_pct = 0;

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hdl
hdl/obb_pkg.sv
hdl/obb_ram.sv
hdl/obb_dp.sv
hdl/obb_ctrl.sv
hdl/obb_overlap_test.sv
verif/tb_top.sv
